// ===== rtl/core/hftd_pkg.sv =====
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; used by every module of the block.
package hftd_pkg;

   localparam int FIELD_BITS  = 9;
   localparam int SYMBOL_BITS = 8;
   localparam int TOTAL_BITS  = 32;

   // Configuration register indexes.
   localparam logic CSR_NODE_COUNT   = 1'b0;
   localparam logic CSR_SYMBOL_TOTAL = 1'b1;

   // Input word kinds carried on tuser.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_BIT  = 1'b1;

   // One tree table entry: internal flag above a symbol or child field.
   typedef struct packed {
      logic                  internal;
      logic [FIELD_BITS-1:0] field;
   } entry_type;

   // One decoded result word.
   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   last;
   } rsp_item_type;

endpackage

// ===== rtl/core/hftd_table.sv =====
// Tree table memory: one write port and one read port with registered data.
// Depends on hftd_pkg for the entry type.
module hftd_table #(
   parameter int TABLE_DEPTH = 512,
   parameter int AW          = $clog2(TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  hftd_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output hftd_pkg::entry_type rd_data
);

   hftd_pkg::entry_type mem [TABLE_DEPTH];
   hftd_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hftd_out_fifo.sv =====
// Two-word result queue in front of the rsp channel.
// Depends on hftd_pkg for the result word type.
module hftd_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hftd_pkg::rsp_item_type push_data,
   output logic                   has_room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hftd_pkg::rsp_item_type out_data
);

   hftd_pkg::rsp_item_type head_ff, head_in;
   hftd_pkg::rsp_item_type tail_ff, tail_in;
   logic [1:0]             count_ff, count_in;
   logic                   pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign has_room  = (count_ff != 2'd2);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            // With one word held the new word becomes the head directly.
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== rtl/core/huffman_table_tree_decoder_unit.sv =====
// Top level of the Huffman tree-walk decoder: walk control, configuration.
// Depends on hftd_pkg, hftd_table and hftd_out_fifo.
//
// Usage. The req channel carries two kinds of word, selected by tuser.
// A load word writes one tree table entry and never returns a result.
// A bit word moves the walk one level down the tree; reaching a leaf
// returns one word on the rsp channel with the symbol, and tlast set when
// that symbol completes the programmed symbol total. Once the total is
// reached, or when it is zero, bit words are taken and dropped.
// A load word, or a bit word that is dropped, does not hold off the next
// word. A live bit word holds off the next word until its entry returns
// from the registered table read, because the next table index depends on
// that entry; its symbol then passes through the result buffer to rsp.
// The entry of the current internal node is held in a register and kept
// up to date by loads to that position, so one table read per bit suffices.
// Reset clears the walk (back at the root), the symbol count, node_count
// to 2 and symbol_total to 0; the table itself is not cleared and must be
// loaded before use. Register writes never move the walk or the count.
// Results queue in a two-word buffer, so the block keeps accepting while
// one result waits; when the receiver stalls long enough to fill it, req
// tready drops until a word is taken.
module huffman_table_tree_decoder_unit #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata, from bit 0: entry_index[8:0], entry_internal, entry_field[8:0],
   // code_bit, four zero bits.
   input  logic [23:0] req_tdata,
   // tuser: kind (0 load, 1 coded bit).
   input  logic        req_tuser,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: symbol[7:0].
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // Configuration writes.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [hftd_pkg::FIELD_BITS:0] DEPTH_W =
      (hftd_pkg::FIELD_BITS+1)'(TABLE_DEPTH);
   localparam int FB = hftd_pkg::FIELD_BITS;

   // Unpacked input fields.
   logic [FB-1:0] in_index;
   logic          in_internal;
   logic [FB-1:0] in_field;
   logic          in_bit;

   assign in_index    = req_tdata[8:0];
   assign in_internal = req_tdata[9];
   assign in_field    = req_tdata[18:10];
   assign in_bit      = req_tdata[19];

   // Walk state and configuration.
   logic                  at_root_ff, at_root_in;
   logic [FB-1:0]         walk_pos_ff, walk_pos_in;
   hftd_pkg::entry_type   node_entry_ff, node_entry_in;
   logic [31:0]           emitted_ff, emitted_in;
   logic                  finished_ff, finished_in;
   logic                  pending_ff, pending_in;
   logic [FB-1:0]         idx_ff, idx_in;
   logic                  idx_ok_ff, idx_ok_in;
   logic [FB-1:0]         node_count_ff;
   logic [31:0]           symbol_total_ff;

   logic                  accept;
   logic                  load_acc;
   logic                  bit_acc;
   logic                  live_bit;
   logic                  load_ok;
   logic                  fifo_room;
   logic                  push;
   hftd_pkg::rsp_item_type push_data;
   hftd_pkg::rsp_item_type out_data;
   hftd_pkg::entry_type   wr_entry;
   hftd_pkg::entry_type   rd_entry;
   hftd_pkg::entry_type   fetched;
   logic [31:0]           emitted_next;

   // While a live bit waits for its table read the next word is held off.
   assign req_tready = !pending_ff && fifo_room;
   assign accept     = req_tvalid && req_tready;
   assign load_acc   = accept && (req_tuser == hftd_pkg::KIND_LOAD);
   assign bit_acc    = accept && (req_tuser == hftd_pkg::KIND_BIT);
   assign live_bit   = bit_acc && !finished_ff && (emitted_ff < symbol_total_ff);
   assign load_ok    = load_acc && ({1'b0, in_index} < DEPTH_W);

   assign wr_entry.internal = in_internal;
   assign wr_entry.field    = in_field;

   hftd_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .AW         (AW)
   ) u_table (
      .clock  (clock),
      .wr_en  (load_ok),
      .wr_addr(in_index[AW-1:0]),
      .wr_data(wr_entry),
      .rd_en  (live_bit),
      .rd_addr(idx_in[AW-1:0]),
      .rd_data(rd_entry)
   );

   // Positions outside the table read as a leaf with symbol zero.
   always_comb begin
      if (idx_ok_ff) begin
         fetched = rd_entry;
      end else begin
         fetched = '0;
      end
   end

   assign emitted_next = emitted_ff + 32'd1;

   always_comb begin
      at_root_in    = at_root_ff;
      walk_pos_in   = walk_pos_ff;
      node_entry_in = node_entry_ff;
      emitted_in    = emitted_ff;
      finished_in   = finished_ff;
      pending_in    = 1'b0;
      push          = 1'b0;
      push_data.symbol = fetched.field[7:0];
      push_data.last   = (emitted_next == symbol_total_ff);

      // Next index: root children sit at node_count-2 and node_count-1,
      // an internal node's children at child-1 and child, all modulo 512.
      if (at_root_ff) begin
         idx_in = node_count_ff + {FB{1'b1}} - 9'd1 + {8'd0, in_bit};
      end else begin
         idx_in = node_entry_ff.field + {FB{1'b1}} + {8'd0, in_bit};
      end
      idx_ok_in = ({1'b0, idx_in} < DEPTH_W);

      if (live_bit) begin
         pending_in = 1'b1;
      end

      // A load to the current node keeps its held copy current.
      if (load_ok && !at_root_ff && (in_index == walk_pos_ff)) begin
         node_entry_in = wr_entry;
      end

      if (pending_ff) begin
         if (fetched.internal) begin
            at_root_in    = 1'b0;
            walk_pos_in   = idx_ff;
            node_entry_in = fetched;
         end else begin
            at_root_in  = 1'b1;
            walk_pos_in = '0;
            emitted_in  = emitted_next;
            push        = 1'b1;
            if (emitted_next == symbol_total_ff) begin
               finished_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_root_ff      <= 1'b1;
         walk_pos_ff     <= '0;
         emitted_ff      <= '0;
         finished_ff     <= 1'b0;
         pending_ff      <= 1'b0;
         node_count_ff   <= 9'd2;
         symbol_total_ff <= '0;
      end else begin
         at_root_ff  <= at_root_in;
         walk_pos_ff <= walk_pos_in;
         emitted_ff  <= emitted_in;
         finished_ff <= finished_in;
         pending_ff  <= pending_in;
         if (csr_we) begin
            case (csr_index)
               hftd_pkg::CSR_NODE_COUNT:   node_count_ff   <= csr_wdata[FB-1:0];
               hftd_pkg::CSR_SYMBOL_TOTAL: symbol_total_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers: the index of the read in flight and the node copy.
   always_ff @(posedge clock) begin
      node_entry_ff <= node_entry_in;
      if (live_bit) begin
         idx_ff    <= idx_in;
         idx_ok_ff <= idx_ok_in;
      end
   end

   hftd_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .has_room (fifo_room),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (out_data)
   );

   assign rsp_tdata = out_data.symbol;
   assign rsp_tlast = out_data.last;

endmodule
